### design/nsfp_pkg.sv
// Shared types, codes and sentence tables of the NMEA sentence field parser.
// No dependencies; nsfp_front, nsfp_back and the top module import this package.
package nsfp_pkg;

  // Parser phase: idle, skip talker letter, four header bytes, body
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_HDR4,
    PH_BODY
  } phase_e;

  // Field table of the current sentence
  typedef enum logic [2:0] {
    TAB_RMC,
    TAB_VTG,
    TAB_GGA,
    TAB_GSA,
    TAB_GSV,
    TAB_NONE
  } tab_e;

  // Sentence kind reported at the end of a sentence
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_RMC,
    KIND_GPVTG,
    KIND_GNVTG,
    KIND_GGA,
    KIND_GPGSV,
    KIND_GLGSV,
    KIND_GSA
  } kind_e;

  // Type words, first header byte in the low octet
  localparam logic [31:0] HdrGprmc = 32'h434D5250;
  localparam logic [31:0] HdrGnrmc = 32'h434D524E;
  localparam logic [31:0] HdrGpvtg = 32'h47545650;
  localparam logic [31:0] HdrGnvtg = 32'h4754564E;
  localparam logic [31:0] HdrGpgga = 32'h41474750;
  localparam logic [31:0] HdrGngga = 32'h4147474E;
  localparam logic [31:0] HdrGpgsv = 32'h56534750;
  localparam logic [31:0] HdrGlgsv = 32'h5653474C;
  localparam logic [31:0] HdrGngsa = 32'h4153474E;
  localparam logic [31:0] HdrGpgsa = 32'h41534750;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;

  localparam logic [4:0] NoField   = 5'd31;
  localparam logic [4:0] FieldSat  = 5'd30;
  localparam logic [4:0] SatField  = 5'd2;
  localparam logic [9:0] SatMax    = 10'd999;
  localparam int unsigned NumSlots = 76;

  // Classified byte passed from front to back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_dollar;
    logic       is_comma;
    logic       is_star;
    logic       is_digit;
    logic [3:0] digit;
  } token_t;

  // One result beat
  typedef struct packed {
    logic [2:0] done_kind;
    logic       write_valid;
    logic [2:0] write_table;
    logic [4:0] write_field;
    logic [3:0] write_pos;
    logic [7:0] write_char;
    logic [9:0] gps_sats;
    logic [9:0] glonass_sats;
  } result_t;

  typedef struct packed {
    tab_e  tab;
    kind_e kind;
  } class_t;

  // Map a type word to its table and kind
  function automatic class_t classify(logic [31:0] w);
    class_t c;
    c.tab  = TAB_NONE;
    c.kind = KIND_NONE;
    case (w)
      HdrGprmc, HdrGnrmc: begin c.tab = TAB_RMC; c.kind = KIND_RMC; end
      HdrGpvtg:           begin c.tab = TAB_VTG; c.kind = KIND_GPVTG; end
      HdrGnvtg:           begin c.tab = TAB_VTG; c.kind = KIND_GNVTG; end
      HdrGpgga, HdrGngga: begin c.tab = TAB_GGA; c.kind = KIND_GGA; end
      HdrGpgsv:           begin c.tab = TAB_GSV; c.kind = KIND_GPGSV; end
      HdrGlgsv:           begin c.tab = TAB_GSV; c.kind = KIND_GLGSV; end
      HdrGngsa, HdrGpgsa: begin c.tab = TAB_GSA; c.kind = KIND_GSA; end
      default: ;
    endcase
    return c;
  endfunction

  // Number of fields in each table
  function automatic logic [4:0] table_count(tab_e t);
    logic [4:0] n;
    case (t)
      TAB_RMC: n = 5'd13;
      TAB_VTG: n = 5'd10;
      TAB_GGA: n = 5'd15;
      TAB_GSA: n = 5'd18;
      TAB_GSV: n = 5'd20;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // First slot of each table in the field store
  function automatic logic [6:0] table_base(tab_e t);
    logic [6:0] b;
    case (t)
      TAB_RMC: b = 7'd0;
      TAB_VTG: b = 7'd13;
      TAB_GGA: b = 7'd23;
      TAB_GSA: b = 7'd38;
      TAB_GSV: b = 7'd56;
      default: b = 7'd0;
    endcase
    return b;
  endfunction

endpackage

### design/nsfp_fifo.sv
// Two-entry queue used between parser stages and at the result side.
// No dependencies.
module nsfp_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store an entry on each accepted beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### design/nsfp_front.sv
// Front end: accepts received bytes, classifies them and queues tokens.
// Depends on nsfp_pkg and nsfp_fifo.
module nsfp_front
  import nsfp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push,
  output logic   full,
  input  logic   [7:0] rx_byte_i,
  output token_t tok_o,
  output logic   tok_empty_o,
  input  logic   tok_pop_i
);

  token_t tok_in;

  // Classify the incoming byte
  always_comb begin
    tok_in.rx_byte   = rx_byte_i;
    tok_in.is_dollar = (rx_byte_i == ChDollar);
    tok_in.is_comma  = (rx_byte_i == ChComma);
    tok_in.is_star   = (rx_byte_i == ChStar);
    tok_in.is_digit  = (rx_byte_i inside {[8'h30:8'h39]});
    tok_in.digit     = rx_byte_i[3:0];
  end

  nsfp_fifo #(
    .Width($bits(token_t))
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (tok_in),
    .full_o  (full),
    .pop_i   (tok_pop_i),
    .rdata_o (tok_o),
    .empty_o (tok_empty_o)
  );

endmodule

### design/nsfp_back.sv
// Back end: sentence state machine, field store, satellite counts, result queue.
// Depends on nsfp_pkg and nsfp_fifo.
module nsfp_back
  import nsfp_pkg::*;
#(
  parameter int unsigned FIELD_CHARS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  token_t  tok_i,
  input  logic    tok_empty_i,
  output logic    tok_pop_o,
  output result_t res_o,
  output logic    empty,
  input  logic    pop
);

  localparam int unsigned CW = $clog2(FIELD_CHARS + 1);
  localparam int unsigned IW = $clog2(FIELD_CHARS);

  phase_e      phase_q, phase_d;
  logic [31:0] hdr_q, hdr_d;
  tab_e        tab_q, tab_d;
  kind_e       kind_q, kind_d;
  logic [4:0]  field_q, field_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [9:0]  acc_q, acc_d;
  logic        run_q, run_d;
  logic [9:0]  gps_q, gps_d;
  logic [9:0]  glo_q, glo_d;

  logic [7:0]    chars_q [NumSlots][FIELD_CHARS];
  logic [CW-1:0] len_q [NumSlots];
  logic [NumSlots-1:0] len_vld_q;

  class_t        cls;
  logic [4:0]    cnt;
  logic [6:0]    slot;
  logic          chr_we, len_we;
  logic [CW-1:0] len_val;
  logic [13:0]   prod;
  logic          out_full;
  logic          step;
  result_t       res;

  assign step      = !tok_empty_i && !out_full;
  assign tok_pop_o = step;

  // Next state and result for one token
  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    tab_d   = tab_q;
    kind_d  = kind_q;
    field_d = field_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    run_d   = run_q;
    gps_d   = gps_q;
    glo_d   = glo_q;
    res     = '0;
    chr_we  = 1'b0;
    len_we  = 1'b0;
    len_val = '0;
    slot    = '0;
    prod    = '0;
    cls     = classify(hdr_q);
    cnt     = table_count(tab_q);
    if (step) begin
      if (tok_i.is_dollar) begin
        phase_d = PH_SKIP;
        field_d = NoField;
        pos_d   = '0;
      end else begin
        case (phase_q)
          PH_IDLE: ;
          PH_SKIP: phase_d = PH_HDR1;
          PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4: begin
            hdr_d   = {tok_i.rx_byte, hdr_q[31:8]};
            phase_d = phase_e'(phase_q + 3'd1);
            if (phase_q == PH_HDR4) begin
              cls    = classify(hdr_d);
              tab_d  = cls.tab;
              kind_d = cls.kind;
            end
          end
          PH_BODY: begin
            if (tab_q == TAB_NONE) begin
              phase_d = PH_IDLE;
            end else if (tok_i.is_comma) begin
              // Open the next field and clear its length
              if (field_q == NoField) begin
                field_d = 5'd0;
              end else if (field_q < FieldSat) begin
                field_d = field_q + 5'd1;
              end
              pos_d = '0;
              if (field_d < cnt) begin
                slot            = table_base(tab_q) + 7'(field_d);
                len_we          = 1'b1;
                res.write_valid = 1'b1;
                res.write_table = tab_q;
                res.write_field = field_d;
                if (tab_q == TAB_GSV && field_d == SatField) begin
                  acc_d = '0;
                  run_d = 1'b1;
                end
              end
            end else if (tok_i.is_star) begin
              // Report the sentence and latch the satellite count
              res.done_kind = kind_q;
              if (kind_q == KIND_GPGSV) gps_d = acc_q;
              if (kind_q == KIND_GLGSV) glo_d = acc_q;
              phase_d = PH_IDLE;
            end else if (field_q < cnt && pos_q < CW'(FIELD_CHARS)) begin
              // Append the character to the open field
              slot            = table_base(tab_q) + 7'(field_q);
              chr_we          = 1'b1;
              len_we          = 1'b1;
              len_val         = pos_q + CW'(1);
              res.write_valid = 1'b1;
              res.write_table = tab_q;
              res.write_field = field_q;
              res.write_pos   = 4'(pos_q);
              res.write_char  = tok_i.rx_byte;
              pos_d           = pos_q + CW'(1);
              if (tab_q == TAB_GSV && field_q == SatField && run_q) begin
                if (tok_i.is_digit) begin
                  prod  = {4'd0, acc_q} * 14'd10 + 14'(tok_i.digit);
                  acc_d = (prod > 14'(SatMax)) ? SatMax : prod[9:0];
                end else begin
                  run_d = 1'b0;
                end
              end
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
    res.gps_sats     = gps_d;
    res.glonass_sats = glo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hdr_q   <= '0;
      tab_q   <= TAB_NONE;
      kind_q  <= KIND_NONE;
      field_q <= NoField;
      pos_q   <= '0;
      acc_q   <= '0;
      run_q   <= 1'b0;
      gps_q   <= '0;
      glo_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      tab_q   <= tab_d;
      kind_q  <= kind_d;
      field_q <= field_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      run_q   <= run_d;
      gps_q   <= gps_d;
      glo_q   <= glo_d;
    end
  end

  // Mark a field length as written; an unmarked slot counts as length zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= '0;
    end else if (len_we) begin
      len_vld_q[slot] <= 1'b1;
    end
  end

  // Field length store
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q[slot] <= len_val;
    end
  end

  // Field character store
  always_ff @(posedge clk_i) begin
    if (chr_we) begin
      chars_q[slot][pos_q[IW-1:0]] <= tok_i.rx_byte;
    end
  end

  nsfp_fifo #(
    .Width($bits(result_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .wdata_i (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

### design/nmea_sentence_field_parser.sv
// NMEA 0183 sentence field parser: one received byte per beat, one result per byte.
// Each result is registered in the result queue, behind the token queue of the front end.
// Throughput: one byte per cycle unless the result queue fills and stalls the back end;
// the back end updates the sentence state per token, with two-entry queues after the front and the back.
// Reset: parser idle, counts and field lengths zero; field characters undefined.
// Depends on nsfp_pkg, nsfp_front, nsfp_back.
module nmea_sentence_field_parser
  import nsfp_pkg::*;
#(
  parameter int unsigned FIELD_CHARS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] done_kind_o,
  output logic       write_valid_o,
  output logic [2:0] write_table_o,
  output logic [4:0] write_field_o,
  output logic [3:0] write_pos_o,
  output logic [7:0] write_char_o,
  output logic [9:0] gps_sats_o,
  output logic [9:0] glonass_sats_o
);

  token_t  tok;
  logic    tok_empty;
  logic    tok_pop;
  result_t res;

  nsfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .tok_o       (tok),
    .tok_empty_o (tok_empty),
    .tok_pop_i   (tok_pop)
  );

  nsfp_back #(
    .FIELD_CHARS(FIELD_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok),
    .tok_empty_i (tok_empty),
    .tok_pop_o   (tok_pop),
    .res_o       (res),
    .empty       (empty),
    .pop         (pop)
  );

  // Split the result beat onto its ports
  assign done_kind_o    = res.done_kind;
  assign write_valid_o  = res.write_valid;
  assign write_table_o  = res.write_table;
  assign write_field_o  = res.write_field;
  assign write_pos_o    = res.write_pos;
  assign write_char_o   = res.write_char;
  assign gps_sats_o     = res.gps_sats;
  assign glonass_sats_o = res.glonass_sats;

endmodule
